[rtl/ufmac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufmac_pkg
// Shared types and constants of the union-find minimum-average engine.
// ---------------------------------------------------------------------------
package ufmac_pkg;

  localparam int NODE_W   = 10;
  localparam int NODES    = 1 << NODE_W;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 40;
  localparam int EDGE_W   = 24;
  localparam int PROD_W   = 64;
  localparam logic [SUM_W-1:0] START_AVG = SUM_W'(1000000);
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1023);

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_FRD,
    DP_FCHK,
    DP_CRD,
    DP_CWR,
    DP_SETV,
    DP_ORDER,
    DP_RDLO,
    DP_RDHI,
    DP_GETHI,
    DP_MERGE,
    DP_WRITE,
    DP_QRD,
    DP_QGET,
    DP_M0,
    DP_M1,
    DP_M2,
    DP_M3,
    DP_DECIDE,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_FRD,
    S_FCHK,
    S_CRD,
    S_CWR,
    S_AFTER,
    S_RDLO,
    S_RDHI,
    S_GETHI,
    S_MERGE,
    S_WRITE,
    S_QRD,
    S_QGET,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_DECIDE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PH_U,
    PH_V,
    PH_Q
  } phase_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pq_eq_cur;
    logic cur_eq_root;
    logic scan_empty;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/union_find_min_avg_component.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// union_find_min_avg_component
// Disjoint-set engine with per-component weight sums; least-average query.
// ---------------------------------------------------------------------------
// Input words (in_*) are edges (in_op 0) or queries (in_op 1). An edge gives
// no output word; a query gives one word on out_* holding best_node and found.
// cfg_data sets node_count; cfg_ready is always high, write only when idle.
// Reset starts a clearing pass that rebuilds the parent and component
// memories; in_ready stays low during it.
// An edge walks each endpoint to its root and compresses the path on it;
// each parent hop costs a parent read and a check, each compressed node a
// read and a write, and the two roots are then linked. A query scans
// node_count nodes: each scanned node needs a root walk, a component read
// and two products, each built in two passes of one 32x24 multiplier.
// One item is in flight at a time.
// The result word sits in an output register. While a stalled receiver holds
// it, edges are still taken, but the next query waits at its end with in_ready
// low until the held word is accepted.
// ---------------------------------------------------------------------------
module union_find_min_avg_component (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_op,
  input  wire logic [ufmac_pkg::NODE_W-1:0]   in_node_u,
  input  wire logic [ufmac_pkg::NODE_W-1:0]   in_node_v,
  input  wire logic [ufmac_pkg::WEIGHT_W-1:0] in_weight,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ufmac_pkg::NODE_W-1:0]   cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ufmac_pkg::NODE_W-1:0]        out_best_node,
  output logic                                out_found
);

  ufmac_pkg::dp_cmd_t  cmd;
  ufmac_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ufmac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ufmac_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_op),
    .in_node_u     (in_node_u),
    .in_node_v     (in_node_v),
    .in_weight     (in_weight),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_node (out_best_node),
    .out_found     (out_found)
  );

endmodule
`default_nettype wire

[rtl/ufmac_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufmac_ctrl
// Sequencer: clearing pass, root walks with compression, link and query scan.
// ---------------------------------------------------------------------------
module ufmac_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  output logic                     in_ready,
  input  wire ufmac_pkg::dp_stat_t stat,
  output ufmac_pkg::dp_cmd_t       cmd
);

  ufmac_pkg::state_t state_r, state_nxt;
  ufmac_pkg::phase_t phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufmac_pkg::S_CLEAR;
      phase_r <= ufmac_pkg::PH_U;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ufmac_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = ufmac_pkg::S_IDLE;
      end
      ufmac_pkg::S_IDLE: begin
        if (in_valid) begin
          phase_nxt = in_op ? ufmac_pkg::PH_Q : ufmac_pkg::PH_U;
          state_nxt = (in_op && stat.scan_empty) ? ufmac_pkg::S_RESULT : ufmac_pkg::S_FRD;
        end
      end
      ufmac_pkg::S_FRD:  state_nxt = ufmac_pkg::S_FCHK;
      ufmac_pkg::S_FCHK: state_nxt = stat.pq_eq_cur ? ufmac_pkg::S_CRD : ufmac_pkg::S_FRD;
      ufmac_pkg::S_CRD:  state_nxt = stat.cur_eq_root ? ufmac_pkg::S_AFTER : ufmac_pkg::S_CWR;
      ufmac_pkg::S_CWR:  state_nxt = ufmac_pkg::S_CRD;
      ufmac_pkg::S_AFTER: begin
        case (phase_r)
          ufmac_pkg::PH_U: begin
            phase_nxt = ufmac_pkg::PH_V;
            state_nxt = ufmac_pkg::S_FRD;
          end
          ufmac_pkg::PH_V: state_nxt = ufmac_pkg::S_RDLO;
          default:         state_nxt = ufmac_pkg::S_QRD;
        endcase
      end
      ufmac_pkg::S_RDLO:  state_nxt = ufmac_pkg::S_RDHI;
      ufmac_pkg::S_RDHI:  state_nxt = ufmac_pkg::S_GETHI;
      ufmac_pkg::S_GETHI: state_nxt = ufmac_pkg::S_MERGE;
      ufmac_pkg::S_MERGE: state_nxt = ufmac_pkg::S_WRITE;
      ufmac_pkg::S_WRITE: state_nxt = ufmac_pkg::S_IDLE;
      ufmac_pkg::S_QRD:   state_nxt = ufmac_pkg::S_QGET;
      ufmac_pkg::S_QGET:  state_nxt = ufmac_pkg::S_M0;
      ufmac_pkg::S_M0:    state_nxt = ufmac_pkg::S_M1;
      ufmac_pkg::S_M1:    state_nxt = ufmac_pkg::S_M2;
      ufmac_pkg::S_M2:    state_nxt = ufmac_pkg::S_M3;
      ufmac_pkg::S_M3:    state_nxt = ufmac_pkg::S_DECIDE;
      ufmac_pkg::S_DECIDE: begin
        state_nxt = stat.scan_last ? ufmac_pkg::S_RESULT : ufmac_pkg::S_FRD;
      end
      ufmac_pkg::S_RESULT: begin
        if (!stat.out_busy) state_nxt = ufmac_pkg::S_IDLE;
      end
      default: state_nxt = ufmac_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = ufmac_pkg::DP_NOP;
    case (state_r)
      ufmac_pkg::S_CLEAR: cmd.op = ufmac_pkg::DP_CLEAR;
      ufmac_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = ufmac_pkg::DP_LOAD;
      end
      ufmac_pkg::S_FRD:  cmd.op = ufmac_pkg::DP_FRD;
      ufmac_pkg::S_FCHK: cmd.op = ufmac_pkg::DP_FCHK;
      ufmac_pkg::S_CRD: begin
        if (!stat.cur_eq_root) cmd.op = ufmac_pkg::DP_CRD;
      end
      ufmac_pkg::S_CWR: cmd.op = ufmac_pkg::DP_CWR;
      ufmac_pkg::S_AFTER: begin
        case (phase_r)
          ufmac_pkg::PH_U: cmd.op = ufmac_pkg::DP_SETV;
          ufmac_pkg::PH_V: cmd.op = ufmac_pkg::DP_ORDER;
          default:         cmd.op = ufmac_pkg::DP_NOP;
        endcase
      end
      ufmac_pkg::S_RDLO:   cmd.op = ufmac_pkg::DP_RDLO;
      ufmac_pkg::S_RDHI:   cmd.op = ufmac_pkg::DP_RDHI;
      ufmac_pkg::S_GETHI:  cmd.op = ufmac_pkg::DP_GETHI;
      ufmac_pkg::S_MERGE:  cmd.op = ufmac_pkg::DP_MERGE;
      ufmac_pkg::S_WRITE:  cmd.op = ufmac_pkg::DP_WRITE;
      ufmac_pkg::S_QRD:    cmd.op = ufmac_pkg::DP_QRD;
      ufmac_pkg::S_QGET:   cmd.op = ufmac_pkg::DP_QGET;
      ufmac_pkg::S_M0:     cmd.op = ufmac_pkg::DP_M0;
      ufmac_pkg::S_M1:     cmd.op = ufmac_pkg::DP_M1;
      ufmac_pkg::S_M2:     cmd.op = ufmac_pkg::DP_M2;
      ufmac_pkg::S_M3:     cmd.op = ufmac_pkg::DP_M3;
      ufmac_pkg::S_DECIDE: cmd.op = ufmac_pkg::DP_DECIDE;
      ufmac_pkg::S_RESULT: cmd.op = ufmac_pkg::DP_RESULT;
      default:             cmd.op = ufmac_pkg::DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

[rtl/ufmac_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufmac_dp
// Datapath: parent and component memories, shared multiplier, result word.
// ---------------------------------------------------------------------------
module ufmac_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ufmac_pkg::dp_cmd_t                  cmd,
  output ufmac_pkg::dp_stat_t                      stat,
  input  wire logic                                in_op,
  input  wire logic [ufmac_pkg::NODE_W-1:0]        in_node_u,
  input  wire logic [ufmac_pkg::NODE_W-1:0]        in_node_v,
  input  wire logic [ufmac_pkg::WEIGHT_W-1:0]      in_weight,
  input  wire logic                                cfg_valid,
  input  wire logic [ufmac_pkg::NODE_W-1:0]        cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ufmac_pkg::NODE_W-1:0]             out_best_node,
  output logic                                     out_found
);

  localparam int NW = ufmac_pkg::NODE_W;
  localparam int SW = ufmac_pkg::SUM_W;
  localparam int EW = ufmac_pkg::EDGE_W;
  localparam int PW = ufmac_pkg::PROD_W;

  logic [SW+EW-1:0] cs_mem [ufmac_pkg::NODES];
  logic [NW-1:0]    par_mem [ufmac_pkg::NODES];

  logic [NW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] node_count_r;
  logic          out_valid_r;
  logic [NW-1:0] out_best_r;
  logic          out_found_r;

  logic [NW-1:0] cur_r, cur_nxt, start_r, start_nxt, root_r, root_nxt;
  logic [NW-1:0] ra_r, ra_nxt, v_r, v_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NW-1:0] idx_r, idx_nxt, best_r, best_nxt;
  logic [ufmac_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic [SW-1:0] hs_r, hs_nxt, ls_r, ls_nxt, num_r, num_nxt, bnum_r, bnum_nxt;
  logic [EW-1:0] he_r, he_nxt, le_r, le_nxt, den_r, den_nxt, bden_r, bden_nxt;
  logic [PW-1:0] pl_r, pl_nxt, pr_r, pr_nxt;
  logic          found_r, found_nxt;

  logic [NW-1:0]    p_q_r;
  logic [SW+EW-1:0] c_q_r;
  logic [NW-1:0]    p_addr, p_wdata, c_addr;
  logic             p_we, c_we;
  logic [SW+EW-1:0] c_wdata;

  logic [SW-1:0] q_sum;
  logic [EW-1:0] q_edges;
  logic [SW:0]   sum_t, sumw_t;
  logic [EW:0]   edg_t, edg1_t;
  logic [31:0]   mul_a;
  logic [EW-1:0] mul_b;
  logic [55:0]   mul_p;
  logic          same;

  assign q_sum   = c_q_r[SW+EW-1:EW];
  assign q_edges = c_q_r[EW-1:0];
  assign same    = (lo_r == hi_r);
  assign sum_t   = {1'b0, hs_r} + {1'b0, ls_r};
  assign edg_t   = {1'b0, he_r} + {1'b0, le_r};
  assign sumw_t  = {1'b0, hs_r} + {{(SW-ufmac_pkg::WEIGHT_W+1){1'b0}}, w_r};
  assign edg1_t  = {1'b0, he_r} + {{EW{1'b0}}, 1'b1};
  assign mul_p   = 56'(mul_a) * 56'(mul_b);

  always_comb begin
    case (cmd.op)
      ufmac_pkg::DP_M0: begin
        mul_a = num_r[31:0];
        mul_b = bden_r;
      end
      ufmac_pkg::DP_M1: begin
        mul_a = {{(64-SW){1'b0}}, num_r[SW-1:32]};
        mul_b = bden_r;
      end
      ufmac_pkg::DP_M2: begin
        mul_a = bnum_r[31:0];
        mul_b = den_r;
      end
      default: begin
        mul_a = {{(64-SW){1'b0}}, bnum_r[SW-1:32]};
        mul_b = den_r;
      end
    endcase
  end

  always_comb begin
    p_addr  = cur_r;
    p_we    = 1'b0;
    p_wdata = root_r;
    c_addr  = hi_r;
    c_we    = 1'b0;
    c_wdata = '0;
    case (cmd.op)
      ufmac_pkg::DP_CLEAR: begin
        p_addr  = clr_r;
        p_we    = 1'b1;
        p_wdata = clr_r;
        c_addr  = clr_r;
        c_we    = 1'b1;
      end
      ufmac_pkg::DP_CWR: p_we = 1'b1;
      ufmac_pkg::DP_RDLO: c_addr = lo_r;
      ufmac_pkg::DP_QRD:  c_addr = root_r;
      ufmac_pkg::DP_WRITE: begin
        p_addr  = lo_r;
        p_we    = 1'b1;
        p_wdata = hi_r;
        c_we    = 1'b1;
        c_wdata = {sumw_t[SW] ? {SW{1'b1}} : sumw_t[SW-1:0],
                   edg1_t[EW] ? {EW{1'b1}} : edg1_t[EW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) par_mem[p_addr] <= p_wdata;
    p_q_r <= par_mem[p_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) cs_mem[c_addr] <= c_wdata;
    c_q_r <= cs_mem[c_addr];
  end

  always_comb begin
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    start_nxt = start_r;
    root_nxt  = root_r;
    ra_nxt    = ra_r;
    v_nxt     = v_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    w_nxt     = w_r;
    hs_nxt    = hs_r;
    ls_nxt    = ls_r;
    he_nxt    = he_r;
    le_nxt    = le_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    bnum_nxt  = bnum_r;
    bden_nxt  = bden_r;
    pl_nxt    = pl_r;
    pr_nxt    = pr_r;
    found_nxt = found_r;
    case (cmd.op)
      ufmac_pkg::DP_CLEAR: clr_nxt = clr_r + NW'(1);
      ufmac_pkg::DP_LOAD: begin
        cur_nxt   = in_op ? NW'(1) : in_node_u;
        start_nxt = in_op ? NW'(1) : in_node_u;
        v_nxt     = in_node_v;
        w_nxt     = in_weight;
        idx_nxt   = NW'(1);
        bnum_nxt  = ufmac_pkg::START_AVG;
        bden_nxt  = EW'(1);
        best_nxt  = '0;
        found_nxt = 1'b0;
      end
      ufmac_pkg::DP_FCHK: begin
        if (p_q_r == cur_r) begin
          root_nxt = cur_r;
          cur_nxt  = start_r;
        end else begin
          cur_nxt = p_q_r;
        end
      end
      ufmac_pkg::DP_CWR: cur_nxt = p_q_r;
      ufmac_pkg::DP_SETV: begin
        ra_nxt    = root_r;
        cur_nxt   = v_r;
        start_nxt = v_r;
      end
      ufmac_pkg::DP_ORDER: begin
        lo_nxt = (ra_r > root_r) ? root_r : ra_r;
        hi_nxt = (ra_r > root_r) ? ra_r : root_r;
      end
      ufmac_pkg::DP_RDHI: begin
        ls_nxt = same ? '0 : q_sum;
        le_nxt = same ? '0 : q_edges;
      end
      ufmac_pkg::DP_GETHI: begin
        hs_nxt = q_sum;
        he_nxt = q_edges;
      end
      ufmac_pkg::DP_MERGE: begin
        hs_nxt = sum_t[SW] ? {SW{1'b1}} : sum_t[SW-1:0];
        he_nxt = edg_t[EW] ? {EW{1'b1}} : edg_t[EW-1:0];
      end
      ufmac_pkg::DP_QGET: begin
        if (q_sum == '0 || q_edges == '0) begin
          num_nxt = '0;
          den_nxt = EW'(1);
        end else begin
          num_nxt = q_sum;
          den_nxt = q_edges;
        end
      end
      ufmac_pkg::DP_M0: pl_nxt = PW'(mul_p);
      ufmac_pkg::DP_M1: pl_nxt = pl_r + {mul_p[31:0], 32'h0};
      ufmac_pkg::DP_M2: pr_nxt = PW'(mul_p);
      ufmac_pkg::DP_M3: pr_nxt = pr_r + {mul_p[31:0], 32'h0};
      ufmac_pkg::DP_DECIDE: begin
        if (pl_r <= pr_r) begin
          bnum_nxt  = num_r;
          bden_nxt  = den_r;
          best_nxt  = idx_r;
          found_nxt = 1'b1;
        end
        idx_nxt   = idx_r + NW'(1);
        cur_nxt   = idx_r + NW'(1);
        start_nxt = idx_r + NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    start_r <= start_nxt;
    root_r  <= root_nxt;
    ra_r    <= ra_nxt;
    v_r     <= v_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    w_r     <= w_nxt;
    hs_r    <= hs_nxt;
    ls_r    <= ls_nxt;
    he_r    <= he_nxt;
    le_r    <= le_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    bnum_r  <= bnum_nxt;
    bden_r  <= bden_nxt;
    pl_r    <= pl_nxt;
    pr_r    <= pr_nxt;
    found_r <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      node_count_r <= ufmac_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      if (cfg_valid) node_count_r <= cfg_data;
      if (cmd.op == ufmac_pkg::DP_RESULT && !stat.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ufmac_pkg::DP_RESULT && !stat.out_busy) begin
      out_best_r  <= found_r ? best_r : '0;
      out_found_r <= found_r;
    end
  end

  assign stat.clr_last    = (clr_r == NW'(ufmac_pkg::NODES - 1));
  assign stat.pq_eq_cur   = (p_q_r == cur_r);
  assign stat.cur_eq_root = (cur_r == root_r);
  assign stat.scan_empty  = (node_count_r == '0);
  assign stat.scan_last   = (idx_r == node_count_r);
  assign stat.out_busy    = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_best_node = out_best_r;
  assign out_found     = out_found_r;

endmodule
`default_nettype wire

[rtl/ufmac_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ufmac_chk
// Port-level checks of the union-find engine, bound to the top level.
// ---------------------------------------------------------------------------
module ufmac_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_op,
  input wire logic [ufmac_pkg::NODE_W-1:0]   in_node_u,
  input wire logic [ufmac_pkg::NODE_W-1:0]   in_node_v,
  input wire logic [ufmac_pkg::WEIGHT_W-1:0] in_weight,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [ufmac_pkg::NODE_W-1:0]   cfg_data,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ufmac_pkg::NODE_W-1:0]   out_best_node,
  input wire logic                           out_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_node) && $stable(out_found))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_node == '0)
    else $error("best_node nonzero without found");

endmodule

bind union_find_min_avg_component ufmac_chk u_chk (.*);
`default_nettype wire
